FILE: rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// types, signature constants and the tail match function shared by the
// script signature detector
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int MAX_MESSAGE_BYTES = 1024;
  localparam int HIST_LEN          = 18;
  localparam int SEQ_LEN           = HIST_LEN + 1;
  localparam int COUNT_W           = 11;
  localparam int NUM_SIGS          = 4;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT   = COUNT_W'(MAX_MESSAGE_BYTES);
  localparam logic [COUNT_W-1:0] THRESH_RESET  = COUNT_W'(1000);

  typedef logic [7:0]                    byte_t;
  typedef logic [HIST_LEN-1:0][7:0]      hist_t;
  typedef logic [SEQ_LEN-1:0][7:0]       seq_t;
  typedef logic [SEQ_LEN-1:0]            care_t;
  typedef logic [COUNT_W-1:0]            count_t;
  typedef logic [NUM_SIGS-1:0]           hits_t;

  // signatures right-justified: byte j is the character j places before the end
  localparam seq_t SIG_PRIMARY = seq_t'("eval(unescape(");
  localparam seq_t SIG_PARSE   = seq_t'("parseInt");
  localparam seq_t SIG_FROMCC  = seq_t'("String.fromCharCode");
  localparam seq_t SIG_EVAL    = seq_t'("eval(");

  localparam care_t CARE_PRIMARY = care_t'(19'h03FFF);
  localparam care_t CARE_PARSE   = care_t'(19'h000FF);
  localparam care_t CARE_FROMCC  = care_t'(19'h7FFFF);
  localparam care_t CARE_EVAL    = care_t'(19'h0001F);

  localparam int HIT_PRIMARY = 0;
  localparam int HIT_PARSE   = 1;
  localparam int HIT_FROMCC  = 2;
  localparam int HIT_EVAL    = 3;

  typedef struct packed {
    logic  last_byte;
    byte_t data_byte;
  } item_t;

  // last field in the lowest bits
  typedef struct packed {
    count_t digit_count;
    logic   secondary_hit;
    logic   primary_hit;
    logic   malicious;
  } result_t;

  localparam int TDATA_W = ((($bits(result_t)) + 7) / 8) * 8;

  function automatic logic tail_match(input seq_t seq, input seq_t sig, input care_t care);
    logic hit;
    hit = 1'b1;
    for (int j = 0; j < SEQ_LEN; j++) begin
      if (care[j] && (seq[j] != sig[j])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

FILE: rtl/ssd_scan.sv
// ----------------------------------------------------------------------------
// ssd_scan
// history window, signature hit flags and digit counter for one message;
// forms the verdict for the byte in the input register
// ----------------------------------------------------------------------------
module ssd_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  ssd_pkg::item_t   item,
  input  ssd_pkg::count_t  threshold,
  output ssd_pkg::result_t verdict
);
  import ssd_pkg::*;

  hist_t  hist;
  hits_t  hits;
  count_t count;

  seq_t   seq;
  hits_t  hits_next;
  count_t count_next;
  logic   is_digit;

  always_comb begin
    seq = {hist, item.data_byte};
    hits_next = hits;
    hits_next[HIT_PRIMARY] = hits[HIT_PRIMARY] | tail_match(seq, SIG_PRIMARY, CARE_PRIMARY);
    hits_next[HIT_PARSE]   = hits[HIT_PARSE]   | tail_match(seq, SIG_PARSE, CARE_PARSE);
    hits_next[HIT_FROMCC]  = hits[HIT_FROMCC]  | tail_match(seq, SIG_FROMCC, CARE_FROMCC);
    hits_next[HIT_EVAL]    = hits[HIT_EVAL]    | tail_match(seq, SIG_EVAL, CARE_EVAL);
    is_digit = (item.data_byte >= 8'h30) && (item.data_byte <= 8'h39);
    count_next = count;
    if (is_digit && (count < COUNT_LIMIT)) begin
      count_next = count + count_t'(1);
    end
    verdict.primary_hit   = hits_next[HIT_PRIMARY];
    verdict.secondary_hit = hits_next[HIT_PARSE] | hits_next[HIT_FROMCC] | hits_next[HIT_EVAL];
    verdict.digit_count   = count_next;
    verdict.malicious     = verdict.primary_hit
                          | (verdict.secondary_hit & (count_next > threshold));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist  <= '0;
      hits  <= '0;
      count <= '0;
    end else if (advance) begin
      if (item.last_byte) begin
        hist  <= '0;
        hits  <= '0;
        count <= '0;
      end else begin
        hist  <= {hist[HIST_LEN-2:0], item.data_byte};
        hits  <= hits_next;
        count <= count_next;
      end
    end
  end

endmodule

FILE: rtl/ssd_out_reg.sv
// ----------------------------------------------------------------------------
// ssd_out_reg
// result register on the master side of the stream
// ----------------------------------------------------------------------------
module ssd_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  ssd_pkg::result_t              verdict,
  output logic                          free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ssd_pkg::TDATA_W-1:0]   m_tdata  // malicious, primary_hit, secondary_hit, digit_count
);
  import ssd_pkg::*;

  result_t result;

  assign free    = !m_tvalid || m_tready;
  assign m_tdata = TDATA_W'(result);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= verdict;
    end
  end

endmodule

FILE: rtl/script_signature_detector.sv
// ----------------------------------------------------------------------------
// script_signature_detector
// scans message bytes for obfuscated script signatures and emits one verdict
// per message on the byte marked last
// ----------------------------------------------------------------------------
// m_tvalid rises in the cycle after the last byte leaves the input register
// throughput: one byte per cycle; signature compare and digit count are
//   combinational between the input register and the scan state; a last byte
//   waits while the previous verdict is still held unaccepted
// reset: synchronous; clears window, hit flags, digit count and both stages,
//   threshold returns to 1000
module script_signature_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // data_byte
  input  logic                          s_tlast,  // last_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ssd_pkg::TDATA_W-1:0]   m_tdata,  // malicious, primary_hit, secondary_hit, digit_count
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssd_pkg::COUNT_W-1:0]   cfg_data  // digit_threshold
);
  import ssd_pkg::*;

  item_t   in_item;
  logic    in_valid;
  count_t  threshold;
  result_t verdict;
  logic    out_free;
  logic    advance;

  assign advance   = in_valid && (!in_item.last_byte || out_free);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= '{last_byte: s_tlast, data_byte: s_tdata};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  ssd_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (in_item),
    .threshold (threshold),
    .verdict   (verdict)
  );

  ssd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && in_item.last_byte),
    .verdict  (verdict),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && in_item.last_byte) |=> m_tvalid)
    else $error("verdict not registered after last byte");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:3] <= COUNT_LIMIT))
    else $error("digit count above limit");

  a_verdict_rule: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[1] || (m_tdata[2] && (m_tdata[13:3] > threshold)))))
    else $error("malicious flag inconsistent with hits");
`endif

endmodule
